### hdl/sm4cbc_pkg.sv
// shared types, constants and tables for the sm4 block cipher unit
package sm4cbc_pkg;

   localparam int BLOCK_W    = 128;
   localparam int HALF_W     = 64;
   localparam int WORD_W     = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_HIGH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_LOW     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAIN_MODE = 3'd4;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   localparam logic [WORD_W-1:0] FK [4] = '{
      32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
   };

   localparam logic [7:0] SBOX [256] = '{
      8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7, 8'h16, 8'hb6, 8'h14, 8'hc2,
      8'h28, 8'hfb, 8'h2c, 8'h05, 8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
      8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9c, 8'h42, 8'h50, 8'hf4,
      8'h91, 8'hef, 8'h98, 8'h7a, 8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
      8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95, 8'h80, 8'hdf, 8'h94, 8'hfa,
      8'h75, 8'h8f, 8'h3f, 8'ha6, 8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
      8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8, 8'h68, 8'h6b, 8'h81, 8'hb2,
      8'h71, 8'h64, 8'hda, 8'h8b, 8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
      8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2, 8'h25, 8'h22, 8'h7c, 8'h3b,
      8'h01, 8'h21, 8'h78, 8'h87, 8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
      8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e, 8'hea, 8'hbf, 8'h8a, 8'hd2,
      8'h40, 8'hc7, 8'h38, 8'hb5, 8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
      8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55, 8'had, 8'h93, 8'h32, 8'h30,
      8'hf5, 8'h8c, 8'hb1, 8'he3, 8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
      8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f, 8'hd5, 8'hdb, 8'h37, 8'h45,
      8'hde, 8'hfd, 8'h8e, 8'h2f, 8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
      8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f, 8'h11, 8'hd9, 8'h5c, 8'h41,
      8'h1f, 8'h10, 8'h5a, 8'hd8, 8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
      8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0, 8'h89, 8'h69, 8'h97, 8'h4a,
      8'h0c, 8'h96, 8'h77, 8'h7e, 8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
      8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20, 8'h79, 8'hee, 8'h5f, 8'h3e,
      8'hd7, 8'hcb, 8'h39, 8'h48
   };

   typedef enum logic [2:0] {
      ST_KEY_LOAD,
      ST_KEY_RUN,
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } state_type;

   // ck word: byte j is (4i+j)*7 mod 256, most significant byte first
   function automatic logic [WORD_W-1:0] ck_word(input logic [7:0] idx);
      logic [WORD_W-1:0] w;
      logic [7:0]        b;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         b = (idx * 8'd4 + 8'(j)) * 8'd7;
         w = {w[WORD_W-9:0], b};
      end
      return w;
   endfunction

endpackage

### hdl/sm4cbc_round_unit.sv
// shared sm4 round datapath: byte substitution and linear mix for data or key schedule
module sm4cbc_round_unit (
   input  logic [sm4cbc_pkg::WORD_W-1:0] w0,
   input  logic [sm4cbc_pkg::WORD_W-1:0] mix,
   input  logic                          key_sched,
   output logic [sm4cbc_pkg::WORD_W-1:0] nx
);
   import sm4cbc_pkg::*;

   logic [WORD_W-1:0] sub;
   logic [WORD_W-1:0] lin;

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         sub[8*b +: 8] = SBOX[mix[8*b +: 8]];
      end
      if (key_sched) begin
         lin = sub ^ {sub[18:0], sub[31:19]} ^ {sub[8:0], sub[31:9]};
      end else begin
         lin = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
               ^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
      end
      nx = w0 ^ lin;
   end

endmodule

### hdl/sm4_block_cipher_cbc_unit.sv
// sm4 block cipher unit with ecb/cbc chaining, iterative one round per cycle
//
// req channel: one 128-bit block per beat; tdata holds data_high in the low 64 bits,
// tuser holds func (bit 0, 1 decrypts) and first_block (bit 1, reloads the chain
// register from the iv). rsp channel: one output block per input beat, same packing.
// csr port: 64-bit registers at byte address 8*i: key_high, key_low, iv_high, iv_low,
// chain_mode; reads return the stored value.
// each block runs 32 rounds through the single shared round unit, then an output load
// step; a new beat is taken only once the unit is back in idle.
// round keys sit in a 32-entry memory whose registered read runs one round ahead.
// after reset and after every key write the key schedule runs a key load step and 32
// rounds through the same round unit, with req_tready low.
// a finished block waits in the output register; the next beat is taken meanwhile,
// but its result is held back in the unit until the receiver takes the previous one.
module sm4_block_cipher_cbc_unit #(
   parameter int ROUND_COUNT = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sm4cbc_pkg::BLOCK_W-1:0]    req_tdata,   // data_high, data_low
   input  logic [1:0]                        req_tuser,   // func, first_block
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sm4cbc_pkg::BLOCK_W-1:0]    rsp_tdata,   // result_high, result_low
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sm4cbc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sm4cbc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sm4cbc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready
);
   import sm4cbc_pkg::*;

   localparam int CntW = $clog2(ROUND_COUNT);
   localparam logic [CntW-1:0] LastRound = CntW'(ROUND_COUNT - 1);

   state_type state_ff, state_in;

   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [WORD_W-1:0] win_ff [4];
   logic [WORD_W-1:0] win_in [4];
   logic [WORD_W-1:0] rk_mem [ROUND_COUNT];
   logic [WORD_W-1:0] rk_rd_ff;
   logic [CntW-1:0]   rk_raddr;
   logic              rk_we;
   logic              func_ff, func_in;
   logic [BLOCK_W-1:0] data_ff, data_in;
   logic [BLOCK_W-1:0] chain_ff, chain_in;
   logic [HALF_W-1:0] key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic              chain_mode_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 csr_wr;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 key_wr;
   logic                 req_acc;
   logic                 req_func;
   logic [BLOCK_W-1:0]   req_block;
   logic [BLOCK_W-1:0]   chain_sel;
   logic [BLOCK_W-1:0]   cipher_out;
   logic [BLOCK_W-1:0]   result;
   logic                 key_sched;
   logic [WORD_W-1:0]    round_key;
   logic [WORD_W-1:0]    mix;
   logic [WORD_W-1:0]    nx;
   logic [CntW-1:0]      next_idx;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign key_wr     = csr_wr & ((csr_idx == CSR_KEY_HIGH) | (csr_idx == CSR_KEY_LOW));

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         iv_high_ff    <= '0;
         iv_low_ff     <= '0;
         chain_mode_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_KEY_HIGH:   key_high_ff   <= csr_pwdata;
            CSR_KEY_LOW:    key_low_ff    <= csr_pwdata;
            CSR_IV_HIGH:    iv_high_ff    <= csr_pwdata;
            CSR_IV_LOW:     iv_low_ff     <= csr_pwdata;
            CSR_CHAIN_MODE: chain_mode_ff <= csr_pwdata[0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_KEY_HIGH:   csr_prdata = key_high_ff;
         CSR_KEY_LOW:    csr_prdata = key_low_ff;
         CSR_IV_HIGH:    csr_prdata = iv_high_ff;
         CSR_IV_LOW:     csr_prdata = iv_low_ff;
         CSR_CHAIN_MODE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, chain_mode_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // request side
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign req_func   = req_tuser[0];
   assign req_block  = {req_tdata[HALF_W-1:0], req_tdata[BLOCK_W-1:HALF_W]};
   assign chain_sel  = req_tuser[1] ? {iv_high_ff, iv_low_ff} : chain_ff;

   // round key memory, read one round ahead
   assign next_idx = (state_ff == ST_RUN) ? cnt_ff + 1'b1 : '0;
   assign rk_raddr = ((state_ff == ST_RUN) ? func_ff : req_func) == FUNC_DECRYPT
                     ? LastRound - next_idx : next_idx;
   assign rk_we    = (state_ff == ST_KEY_RUN);

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_mem[cnt_ff] <= nx;
      end
      rk_rd_ff <= rk_mem[rk_raddr];
   end

   // shared round unit
   assign key_sched = (state_ff == ST_KEY_RUN);
   assign round_key = key_sched ? ck_word(8'(cnt_ff)) : rk_rd_ff;
   assign mix       = win_ff[1] ^ win_ff[2] ^ win_ff[3] ^ round_key;

   sm4cbc_round_unit u_round (
      .w0        (win_ff[0]),
      .mix       (mix),
      .key_sched (key_sched),
      .nx        (nx)
   );

   assign cipher_out = {win_ff[3], win_ff[2], win_ff[1], win_ff[0]};
   assign result     = (chain_mode_ff && func_ff == FUNC_DECRYPT) ? cipher_out ^ chain_ff
                                                                  : cipher_out;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      win_in       = win_ff;
      func_in      = func_ff;
      data_in      = data_ff;
      chain_in     = chain_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         ST_KEY_LOAD: begin
            win_in[0] = key_high_ff[HALF_W-1:WORD_W] ^ FK[0];
            win_in[1] = key_high_ff[WORD_W-1:0] ^ FK[1];
            win_in[2] = key_low_ff[HALF_W-1:WORD_W] ^ FK[2];
            win_in[3] = key_low_ff[WORD_W-1:0] ^ FK[3];
            cnt_in    = '0;
            state_in  = ST_KEY_RUN;
         end
         ST_KEY_RUN, ST_RUN: begin
            win_in = '{win_ff[1], win_ff[2], win_ff[3], nx};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastRound) begin
               state_in = (state_ff == ST_KEY_RUN) ? ST_IDLE : ST_OUT;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               func_in  = req_func;
               data_in  = req_block;
               chain_in = chain_sel;
               if (chain_mode_ff && req_func == FUNC_ENCRYPT) begin
                  win_in = '{req_block[127:96] ^ chain_sel[127:96],
                             req_block[95:64] ^ chain_sel[95:64],
                             req_block[63:32] ^ chain_sel[63:32],
                             req_block[31:0] ^ chain_sel[31:0]};
               end else begin
                  win_in = '{req_block[127:96], req_block[95:64],
                             req_block[63:32], req_block[31:0]};
               end
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = result;
               rsp_valid_in = 1'b1;
               if (chain_mode_ff) begin
                  chain_in = (func_ff == FUNC_DECRYPT) ? data_ff : result;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_KEY_LOAD;
      endcase
      if (key_wr) begin
         state_in = ST_KEY_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_KEY_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      func_ff     <= func_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[HALF_W-1:0], rsp_data_ff[BLOCK_W-1:HALF_W]};

   // checks
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input beat taken while a block is in progress");

   a_key_write_blocks: assert property (@(posedge clock) disable iff (reset)
      key_wr |=> !req_tready && state_ff == ST_KEY_LOAD)
      else $error("key write did not restart the key schedule");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_tvalid && !rsp_tready |=> state_ff == ST_OUT)
      else $error("finished block overwrote a result still waiting");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the output load step");

endmodule

### sim/testbench.sv
// self-checking testbench for the sm4 ecb/cbc block cipher unit with a scoreboard class
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sm4cbc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 600;

   typedef struct {
      logic [HALF_W-1:0] result_high;
      logic [HALF_W-1:0] result_low;
   } cipher_block_type;

   class cipher_predictor;
      logic [WORD_W-1:0] subkeys [32];
      logic [HALF_W-1:0] key_high, key_low, iv_high, iv_low, chain_high, chain_low;
      bit                chain_on;
      cipher_block_type  expected_blocks [$];
      int                mismatches;

      function new();
         key_high = '0;
         key_low = '0;
         iv_high = '0;
         iv_low = '0;
         chain_high = '0;
         chain_low = '0;
         chain_on = 0;
         mismatches = 0;
         expand_round_keys();
      endfunction

      function logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] v, int n);
         return (v << n) | (v >> (WORD_W - n));
      endfunction

      function logic [WORD_W-1:0] sub_word(logic [WORD_W-1:0] v);
         return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
      endfunction

      function void expand_round_keys();
         logic [WORD_W-1:0] k [4];
         logic [WORD_W-1:0] ck, t, nk;
         k[0] = key_high[63:32] ^ FK[0];
         k[1] = key_high[31:0] ^ FK[1];
         k[2] = key_low[63:32] ^ FK[2];
         k[3] = key_low[31:0] ^ FK[3];
         for (int i = 0; i < 32; i++) begin
            ck = {8'((4 * i) * 7), 8'((4 * i + 1) * 7), 8'((4 * i + 2) * 7),
                  8'((4 * i + 3) * 7)};
            t = sub_word(k[1] ^ k[2] ^ k[3] ^ ck);
            nk = k[0] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
            subkeys[i] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
         end
      endfunction

      // returns {high, low} of the processed block
      function logic [BLOCK_W-1:0] run_rounds(logic [BLOCK_W-1:0] blk, bit backward);
         logic [WORD_W-1:0] w [4];
         logic [WORD_W-1:0] t, nx;
         w[0] = blk[127:96];
         w[1] = blk[95:64];
         w[2] = blk[63:32];
         w[3] = blk[31:0];
         for (int i = 0; i < 32; i++) begin
            t = sub_word(w[1] ^ w[2] ^ w[3] ^ subkeys[backward ? 31 - i : i]);
            nx = w[0] ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
            w[0] = w[1];
            w[1] = w[2];
            w[2] = w[3];
            w[3] = nx;
         end
         return {w[3], w[2], w[1], w[0]};
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_KEY_HIGH: begin
               key_high = value;
               expand_round_keys();
            end
            CSR_KEY_LOW: begin
               key_low = value;
               expand_round_keys();
            end
            CSR_IV_HIGH:    iv_high = value;
            CSR_IV_LOW:     iv_low = value;
            CSR_CHAIN_MODE: chain_on = value[0];
            default: ;
         endcase
      endfunction

      function void accept_block(logic func, logic first, logic [HALF_W-1:0] dh,
                                 logic [HALF_W-1:0] dl);
         logic [BLOCK_W-1:0] r;
         cipher_block_type   e;
         if (first) begin
            chain_high = iv_high;
            chain_low = iv_low;
         end
         if (!chain_on) begin
            r = run_rounds({dh, dl}, func == FUNC_DECRYPT);
         end else if (func == FUNC_DECRYPT) begin
            r = run_rounds({dh, dl}, 1'b1) ^ {chain_high, chain_low};
            chain_high = dh;
            chain_low = dl;
         end else begin
            r = run_rounds({dh ^ chain_high, dl ^ chain_low}, 1'b0);
            {chain_high, chain_low} = r;
         end
         e.result_high = r[127:64];
         e.result_low = r[63:0];
         expected_blocks.push_back(e);
      endfunction

      function void match_block(logic [HALF_W-1:0] rh, logic [HALF_W-1:0] rl);
         cipher_block_type e;
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result beat %h %h", $time, rh, rl);
            mismatches++;
            return;
         end
         e = expected_blocks.pop_front();
         if (rh !== e.result_high) begin
            $display("%0t: result_high expected %h, got %h", $time, e.result_high, rh);
            mismatches++;
         end
         if (rl !== e.result_low) begin
            $display("%0t: result_low expected %h, got %h", $time, e.result_low, rl);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [BLOCK_W-1:0]    req_tdata = '0;   // data_high, data_low
   logic [1:0]            req_tuser = '0;   // func, first_block
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [BLOCK_W-1:0]    rsp_tdata;        // result_high, result_low
   logic                  csr_psel = 0;
   logic                  csr_penable = 0;
   logic                  csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cipher_predictor predictor = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_orders = 0;
   int stall_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   sm4_block_cipher_cbc_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // receiver: random back-pressure plus long holds on request
   always @(negedge clock) begin
      if (stall_orders != stall_seen) begin
         stall_seen = stall_orders;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 0;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         predictor.match_block(rsp_tdata[63:0], rsp_tdata[127:64]);
   end

   function automatic logic [HALF_W-1:0] pick_half();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic push_block(logic func, logic first, logic [HALF_W-1:0] dh,
                             logic [HALF_W-1:0] dl);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = {dl, dh};
      req_tuser = {first, func};
      do @(posedge clock); while (!req_tready);
      predictor.accept_block(func, first, dh, dl);
   endtask

   // drop valid and wait for every outstanding block to come back
   task automatic settle();
      @(negedge clock);
      req_tvalid = 0;
      while (predictor.expected_blocks.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      predictor.write_register(idx, value);
   endtask

   task automatic directed_blocks();
      // zero key after reset, ecb
      push_block(FUNC_ENCRYPT, 1'b0, '0, '0);
      push_block(FUNC_ENCRYPT, 1'b0, '1, '1);
      push_block(FUNC_DECRYPT, 1'b0, '1, '0);
      settle();
      csr_write(CSR_KEY_HIGH, 64'h0123456789abcdef);
      csr_write(CSR_KEY_LOW, 64'hfedcba9876543210);
      push_block(FUNC_ENCRYPT, 1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
      push_block(FUNC_DECRYPT, 1'b0, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
      settle();
      csr_write(CSR_IV_HIGH, {$urandom, $urandom});
      csr_write(CSR_IV_LOW, {$urandom, $urandom});
      // first block under ecb loads the chain but leaves the result alone
      push_block(FUNC_ENCRYPT, 1'b1, pick_half(), pick_half());
      settle();
      csr_write(CSR_CHAIN_MODE, 64'd1);
      push_block(FUNC_ENCRYPT, 1'b0, pick_half(), pick_half());
      push_block(FUNC_ENCRYPT, 1'b0, pick_half(), pick_half());
      push_block(FUNC_DECRYPT, 1'b0, pick_half(), pick_half());
      push_block(FUNC_ENCRYPT, 1'b0, pick_half(), pick_half());
      push_block(FUNC_DECRYPT, 1'b1, pick_half(), pick_half());
      push_block(FUNC_DECRYPT, 1'b0, pick_half(), pick_half());
      settle();
      // new iv only counts from the next first block
      csr_write(CSR_IV_HIGH, '1);
      csr_write(CSR_IV_LOW, '1);
      push_block(FUNC_DECRYPT, 1'b0, pick_half(), pick_half());
      push_block(FUNC_ENCRYPT, 1'b1, pick_half(), pick_half());
      push_block(FUNC_ENCRYPT, 1'b0, pick_half(), pick_half());
      settle();
      csr_write(CSR_KEY_HIGH, '1);
      csr_write(CSR_KEY_LOW, '1);
      push_block(FUNC_ENCRYPT, 1'b1, '1, '1);
      push_block(FUNC_DECRYPT, 1'b0, '0, '0);
      settle();
   endtask

   task automatic random_blocks(int count);
      int   left;
      int   run_len;
      logic run_func;
      logic run_first;
      left = count;
      while (left > 0) begin
         run_len = $urandom_range(1, 12);
         run_func = 1'($urandom_range(1));
         run_first = ($urandom_range(19) != 0);
         for (int j = 0; j < run_len && left > 0; j++) begin
            push_block(($urandom_range(9) == 0) ? ~run_func : run_func,
                       (j == 0) ? run_first : ($urandom_range(49) == 0),
                       pick_half(), pick_half());
            left--;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;
      directed_blocks();
      for (int seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 21 : (seg < 4) ? 75 : 0;
         recv_idle_pct = (seg < 2) ? 75 : (seg < 4) ? 21 : 0;
         settle();
         csr_write(CSR_KEY_HIGH, (seg == 0) ? '1 : (seg == 5) ? '0 : {$urandom, $urandom});
         csr_write(CSR_KEY_LOW, (seg == 0) ? '1 : (seg == 5) ? '0 : {$urandom, $urandom});
         csr_write(CSR_IV_HIGH, (seg == 1) ? '1 : (seg == 4) ? '0 : {$urandom, $urandom});
         csr_write(CSR_IV_LOW, (seg == 1) ? '1 : (seg == 4) ? '0 : {$urandom, $urandom});
         csr_write(CSR_CHAIN_MODE, 64'((seg % 3) != 1));
         if (seg == 4)
            stall_orders++;
         random_blocks(240);
      end
      settle();
      repeat (40) @(posedge clock);
      if (predictor.mismatches == 0 && predictor.expected_blocks.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

### sim.f
hdl/sm4cbc_pkg.sv
hdl/sm4cbc_round_unit.sv
hdl/sm4_block_cipher_cbc_unit.sv
sim/testbench.sv
